@@ src/c8x_pkg.sv @@
// Shared types, codes and constants of the CHIP-8 execute core.
package c8x_pkg;

    localparam int MEMORY_BYTES  = 4096;
    localparam int MEM_AW        = 12;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int FONT_BYTES    = 80;
    localparam logic [11:0] START_PC = 12'h200;
    localparam logic [11:0] ADDR_MAX = 12'hFFF;

    localparam logic [15:0] WORD_CLS = 16'h00E0;
    localparam logic [15:0] WORD_RET = 16'h00EE;

    localparam logic [7:0] MISC_DELAY_GET = 8'h07;
    localparam logic [7:0] MISC_WAIT_KEY  = 8'h0A;
    localparam logic [7:0] MISC_DELAY_SET = 8'h15;
    localparam logic [7:0] MISC_SOUND_SET = 8'h18;
    localparam logic [7:0] MISC_ADD_I     = 8'h1E;
    localparam logic [7:0] MISC_FONT      = 8'h29;
    localparam logic [7:0] MISC_BCD       = 8'h33;
    localparam logic [7:0] MISC_STORE     = 8'h55;
    localparam logic [7:0] MISC_FILL      = 8'h65;
    localparam logic [7:0] KEY_SKIP_DOWN  = 8'h9E;
    localparam logic [7:0] KEY_SKIP_UP    = 8'hA1;

    typedef enum logic [2:0] {
        KIND_LOAD = 3'd0,
        KIND_EXEC = 3'd1,
        KIND_TICK = 3'd2,
        KIND_KEY  = 3'd3,
        KIND_ROW  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_BAD   = 3'd1,
        STAT_WAIT  = 3'd2,
        STAT_OVER  = 3'd3,
        STAT_UNDER = 3'd4
    } stat_code_t;

    typedef enum logic [3:0] {
        GRP_SYS         = 4'h0,
        GRP_JUMP        = 4'h1,
        GRP_CALL        = 4'h2,
        GRP_SKIP_EQ_IMM = 4'h3,
        GRP_SKIP_NE_IMM = 4'h4,
        GRP_SKIP_EQ_REG = 4'h5,
        GRP_SET_IMM     = 4'h6,
        GRP_ADD_IMM     = 4'h7,
        GRP_ALU         = 4'h8,
        GRP_SKIP_NE_REG = 4'h9,
        GRP_SET_I       = 4'hA,
        GRP_JUMP_OFS    = 4'hB,
        GRP_RAND        = 4'hC,
        GRP_DRAW        = 4'hD,
        GRP_KEY         = 4'hE,
        GRP_MISC        = 4'hF
    } grp_t;

    typedef enum logic [3:0] {
        ALU_MOV  = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } alu_t;

    typedef enum logic [2:0] {
        CLS_SIMPLE,
        CLS_CLEAR,
        CLS_RET,
        CLS_DRAW,
        CLS_BCD,
        CLS_STORE,
        CLS_FILL
    } cls_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_TICK,
        ST_KEY,
        ST_ROW,
        ST_UNKNOWN,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_FETCH_END,
        ST_READ_X,
        ST_READ_Y,
        ST_EXEC,
        ST_CLEAR,
        ST_RET,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_BCD,
        ST_STORE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        ctl_state_t op;
        logic       accept;
    } dp_cmd_t;

    typedef struct packed {
        logic  init_done;
        kind_t kind;
        cls_t  cls;
        logic  step_last;
        logic  out_free;
    } dp_stat_t;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 7'(FONT_BYTES))
        begin
            b = FONT_ROM[idx];
        end
        return b;
    endfunction

endpackage

@@ src/c8x_ram.sv @@
// Generic simple dual-port RAM with registered read.
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rd_data_reg <= store_reg[raddr];
    end

    assign rdata = rd_data_reg;
endmodule

@@ src/c8x_ctrl.sv @@
// Sequencer of the CHIP-8 core: walks each transaction through its steps.
module c8x_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output c8x_pkg::dp_cmd_t  cmd,
    input  c8x_pkg::dp_stat_t stat
);
    import c8x_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.op     = state_reg;
        cmd.accept = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.init_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.kind)
                    KIND_LOAD: state_next = ST_LOAD;
                    KIND_EXEC: state_next = ST_FETCH_HI;
                    KIND_TICK: state_next = ST_TICK;
                    KIND_KEY:  state_next = ST_KEY;
                    KIND_ROW:  state_next = ST_ROW;
                    default:   state_next = ST_UNKNOWN;
                endcase
            end
            ST_LOAD, ST_TICK, ST_KEY, ST_ROW, ST_UNKNOWN, ST_RET:
            begin
                state_next = ST_FINISH;
            end
            ST_FETCH_HI:  state_next = ST_FETCH_LO;
            ST_FETCH_LO:  state_next = ST_FETCH_END;
            ST_FETCH_END: state_next = ST_READ_X;
            ST_READ_X:    state_next = ST_READ_Y;
            ST_READ_Y:    state_next = ST_EXEC;
            ST_EXEC:
            begin
                unique case (stat.cls)
                    CLS_CLEAR: state_next = ST_CLEAR;
                    CLS_RET:   state_next = ST_RET;
                    CLS_DRAW:  state_next = ST_DRAW_RD;
                    CLS_BCD:   state_next = ST_BCD;
                    CLS_STORE: state_next = ST_STORE;
                    CLS_FILL:  state_next = ST_FILL_RD;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_CLEAR, ST_BCD, ST_STORE:
            begin
                if (stat.step_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DRAW_RD: state_next = ST_DRAW_WR;
            ST_DRAW_WR: state_next = stat.step_last ? ST_FINISH : ST_DRAW_RD;
            ST_FILL_RD: state_next = ST_FILL_WR;
            ST_FILL_WR: state_next = stat.step_last ? ST_FINISH : ST_FILL_RD;
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end
endmodule

@@ src/c8x_dpath.sv @@
// Datapath of the CHIP-8 core: architectural state, memories and result register.
module c8x_dpath #(
    parameter int STACK_DEPTH = 16,
    parameter int FONT_BASE   = 80
) (
    input  logic              clk,
    input  logic              rst_n,
    input  c8x_pkg::dp_cmd_t  cmd,
    output c8x_pkg::dp_stat_t stat,
    input  logic              cfg_valid,
    input  logic              cfg_jump_uses_vx,
    input  logic [2:0]        opcode,
    input  logic [11:0]       load_address,
    input  logic [7:0]        load_byte,
    input  logic [7:0]        random_byte,
    input  logic [3:0]        key_index,
    input  logic              key_down,
    input  logic [4:0]        row_select,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [11:0]       program_counter,
    output logic [15:0]       executed_word,
    output logic [2:0]        status,
    output logic              sound_on,
    output logic              screen_changed,
    output logic [63:0]       row_pixels
);
    import c8x_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    // architectural state
    logic [11:0]    pc_reg, pc_next;
    logic [15:0]    i_reg, i_next;
    logic [7:0]     v_reg [16];
    logic [7:0]     v_next [16];
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]     delay_reg, delay_next;
    logic [7:0]     sound_reg, sound_next;
    logic [63:0]    fb_reg [SCREEN_HEIGHT];
    logic [63:0]    fb_next [SCREEN_HEIGHT];
    logic [15:0]    keys_reg, keys_next;
    logic [3:0]     lkey_reg, lkey_next;
    logic           krcv_reg, krcv_next;
    logic           jump_vx_reg;
    logic [11:0]    init_cnt_reg, init_cnt_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic           hit_reg, hit_next;
    logic           out_valid_reg, out_valid_next;

    // per-transaction working registers
    logic [2:0]     kind_reg;
    logic [11:0]    laddr_reg;
    logic [7:0]     lbyte_reg;
    logic [7:0]     rnd_reg;
    logic [3:0]     kidx_reg;
    logic           kdown_reg;
    logic [4:0]     rsel_reg;
    logic [15:0]    word_reg, word_next;
    logic [7:0]     vx_reg, vx_next;
    logic [7:0]     vy_reg, vy_next;
    stat_code_t     status_reg, status_next;
    logic           changed_reg, changed_next;
    logic [63:0]    row_reg, row_next;

    logic [11:0]    out_pc_reg;
    logic [15:0]    out_word_reg;
    stat_code_t     out_status_reg;
    logic           out_sound_reg;
    logic           out_changed_reg;
    logic [63:0]    out_row_reg;
    logic           out_load;

    // memory ports
    logic           mem_we;
    logic [11:0]    mem_waddr, mem_raddr;
    logic [7:0]     mem_wdata, mem_rdata;
    logic           stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [11:0]    stk_rdata;
    logic [SPW-1:0] sp_dec;

    // decode
    logic [3:0]     fx, fy, fn;
    logic [7:0]     fnn;
    logic [11:0]    fnnn;
    grp_t           grp;
    alu_t           aop;
    cls_t           cls;
    logic [3:0]     ysel;
    logic [11:0]    pc_skip;
    logic [11:0]    i_cnt_addr;
    logic           sp_full;

    logic [4:0]     fb_idx;
    logic [63:0]    fb_rd;
    logic [5:0]     draw_sum;
    logic           draw_last;
    logic [63:0]    sprite_bits;

    logic           in_font;
    logic [11:0]    font_off;
    logic [7:0]     init_byte;

    logic [1:0]     bcd_h;
    logic [6:0]     bcd_rem;
    logic [14:0]    bcd_prod;
    logic [3:0]     bcd_t;
    logic [3:0]     bcd_o;
    logic [7:0]     bcd_digit;

    logic [8:0]     alu_sum;
    logic [7:0]     alu_res;
    logic           alu_flag;
    logic           alu_wflag;
    logic           alu_bad;
    logic [16:0]     add_i_sum;
    logic           key_is_down;

    c8x_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_main_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack_mem (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (pc_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign fx   = word_reg[11:8];
    assign fy   = word_reg[7:4];
    assign fn   = word_reg[3:0];
    assign fnn  = word_reg[7:0];
    assign fnnn = word_reg[11:0];
    assign grp  = grp_t'(word_reg[15:12]);
    assign aop  = alu_t'(fn);

    assign ysel       = (grp == GRP_JUMP_OFS) ? (jump_vx_reg ? fx : 4'd0) : fy;
    assign pc_skip    = pc_reg + 12'd2;
    assign i_cnt_addr = i_reg[11:0] + {7'd0, cnt_reg};
    assign sp_full    = (sp_reg >= SPW'(STACK_DEPTH));
    assign sp_dec     = sp_reg - SPW'(1);
    assign stk_waddr  = sp_reg[SAW-1:0];
    assign stk_raddr  = sp_dec[SAW-1:0];

    // framebuffer has a single read point
    always_comb
    begin
        case (cmd.op)
            ST_CLEAR:   fb_idx = cnt_reg;
            ST_DRAW_WR: fb_idx = draw_sum[4:0];
            default:    fb_idx = rsel_reg;
        endcase
    end
    assign fb_rd       = fb_reg[fb_idx];
    assign draw_sum    = {1'b0, vy_reg[4:0]} + {1'b0, cnt_reg};
    assign draw_last   = (cnt_reg == ({1'b0, fn} - 5'd1)) || (draw_sum == 6'd31);
    assign sprite_bits = {mem_rdata, 56'd0} >> vx_reg[5:0];

    assign in_font   = ({1'b0, init_cnt_reg} >= 13'(FONT_BASE))
                    && ({1'b0, init_cnt_reg} < 13'(FONT_BASE + FONT_BYTES));
    assign font_off  = init_cnt_reg - 12'(FONT_BASE);
    assign init_byte = in_font ? font_byte(font_off[6:0]) : 8'h00;

    // decimal digits of Vx: hundreds by compare, tens by reciprocal multiply
    assign bcd_h    = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign bcd_rem  = 7'(vx_reg - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0)));
    assign bcd_prod = 15'(bcd_rem) * 15'd205;
    assign bcd_t    = bcd_prod[14:11];
    assign bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = {4'd0, bcd_o};
        endcase
    end

    assign alu_sum   = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign add_i_sum = {1'b0, i_reg} + {9'd0, vx_reg};
    assign key_is_down = keys_reg[vx_reg[3:0]];

    always_comb
    begin
        alu_res   = vy_reg;
        alu_flag  = 1'b0;
        alu_wflag = 1'b0;
        alu_bad   = 1'b0;
        unique case (aop)
            ALU_MOV: alu_res = vy_reg;
            ALU_OR:  alu_res = vx_reg | vy_reg;
            ALU_AND: alu_res = vx_reg & vy_reg;
            ALU_XOR: alu_res = vx_reg ^ vy_reg;
            ALU_ADD:
            begin
                alu_res   = alu_sum[7:0];
                alu_flag  = alu_sum[8];
                alu_wflag = 1'b1;
            end
            ALU_SUB:
            begin
                alu_res   = vx_reg - vy_reg;
                alu_flag  = (vx_reg >= vy_reg);
                alu_wflag = 1'b1;
            end
            ALU_SHR:
            begin
                alu_res   = {1'b0, vy_reg[7:1]};
                alu_flag  = vy_reg[0];
                alu_wflag = 1'b1;
            end
            ALU_SUBN:
            begin
                alu_res   = vy_reg - vx_reg;
                alu_flag  = (vy_reg >= vx_reg);
                alu_wflag = 1'b1;
            end
            ALU_SHL:
            begin
                alu_res   = {vy_reg[6:0], 1'b0};
                alu_flag  = vy_reg[7];
                alu_wflag = 1'b1;
            end
            default: alu_bad = 1'b1;
        endcase
    end

    always_comb
    begin
        cls = CLS_SIMPLE;
        unique case (grp)
            GRP_SYS:
            begin
                if (word_reg == WORD_CLS)
                begin
                    cls = CLS_CLEAR;
                end
                else if (word_reg == WORD_RET && sp_reg != '0)
                begin
                    cls = CLS_RET;
                end
            end
            GRP_DRAW:
            begin
                if (fn != 4'd0)
                begin
                    cls = CLS_DRAW;
                end
            end
            GRP_MISC:
            begin
                if (fnn == MISC_BCD)
                begin
                    cls = CLS_BCD;
                end
                else if (fnn == MISC_STORE)
                begin
                    cls = CLS_STORE;
                end
                else if (fnn == MISC_FILL)
                begin
                    cls = CLS_FILL;
                end
            end
            default: cls = CLS_SIMPLE;
        endcase
    end

    assign out_load = (cmd.op == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        stat.init_done = (init_cnt_reg == ADDR_MAX);
        stat.kind      = kind_t'(kind_reg);
        stat.cls       = cls;
        stat.out_free  = !out_valid_reg || out_ready;
        case (cmd.op)
            ST_CLEAR:               stat.step_last = (cnt_reg == 5'd31);
            ST_DRAW_WR:             stat.step_last = draw_last;
            ST_BCD:                 stat.step_last = (cnt_reg == 5'd2);
            ST_STORE, ST_FILL_WR:   stat.step_last = (cnt_reg == {1'b0, fx});
            default:                stat.step_last = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next        = pc_reg;
        i_next         = i_reg;
        v_next         = v_reg;
        sp_next        = sp_reg;
        delay_next     = delay_reg;
        sound_next     = sound_reg;
        fb_next        = fb_reg;
        keys_next      = keys_reg;
        lkey_next      = lkey_reg;
        krcv_next      = krcv_reg;
        init_cnt_next  = init_cnt_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        word_next      = word_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        status_next    = status_reg;
        changed_next   = changed_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_waddr      = laddr_reg;
        mem_wdata      = lbyte_reg;
        mem_raddr      = pc_reg;
        stk_we         = 1'b0;

        unique case (cmd.op)
            ST_INIT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = init_cnt_reg;
                mem_wdata     = init_byte;
                init_cnt_next = init_cnt_reg + 12'd1;
            end
            ST_LOAD:
            begin
                mem_we = 1'b1;
            end
            ST_TICK:
            begin
                if (delay_reg != 8'd0)
                begin
                    delay_next = delay_reg - 8'd1;
                end
                if (sound_reg != 8'd0)
                begin
                    sound_next = sound_reg - 8'd1;
                end
            end
            ST_KEY:
            begin
                if (kdown_reg)
                begin
                    keys_next[kidx_reg] = 1'b1;
                    lkey_next           = kidx_reg;
                    krcv_next           = 1'b1;
                end
                else
                begin
                    keys_next[kidx_reg] = 1'b0;
                end
            end
            ST_ROW:
            begin
                row_next = fb_rd;
            end
            ST_UNKNOWN:
            begin
                status_next = STAT_BAD;
            end
            ST_FETCH_HI:
            begin
                mem_raddr = pc_reg;
            end
            ST_FETCH_LO:
            begin
                word_next[15:8] = mem_rdata;
                mem_raddr       = pc_reg + 12'd1;
            end
            ST_FETCH_END:
            begin
                word_next[7:0] = mem_rdata;
                pc_next        = pc_skip;
            end
            ST_READ_X:
            begin
                vx_next = v_reg[fx];
            end
            ST_READ_Y:
            begin
                vy_next = v_reg[ysel];
            end
            ST_EXEC:
            begin
                cnt_next = 5'd0;
                hit_next = 1'b0;
                unique case (grp)
                    GRP_SYS:
                    begin
                        if (word_reg == WORD_RET)
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = STAT_UNDER;
                            end
                            else
                            begin
                                sp_next = sp_dec;
                            end
                        end
                        else if (word_reg != WORD_CLS)
                        begin
                            status_next = STAT_BAD;
                        end
                    end
                    GRP_JUMP: pc_next = fnnn;
                    GRP_CALL:
                    begin
                        if (sp_full)
                        begin
                            status_next = STAT_OVER;
                        end
                        else
                        begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + SPW'(1);
                            pc_next = fnnn;
                        end
                    end
                    GRP_SKIP_EQ_IMM:
                    begin
                        if (vx_reg == fnn)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    GRP_SKIP_NE_IMM:
                    begin
                        if (vx_reg != fnn)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    GRP_SKIP_EQ_REG:
                    begin
                        if (vx_reg == vy_reg)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    GRP_SET_IMM: v_next[fx] = fnn;
                    GRP_ADD_IMM: v_next[fx] = vx_reg + fnn;
                    GRP_ALU:
                    begin
                        if (alu_bad)
                        begin
                            status_next = STAT_BAD;
                        end
                        else
                        begin
                            v_next[fx] = alu_res;
                            // flag lands last, so it wins when x is F
                            if (alu_wflag)
                            begin
                                v_next[15] = {7'd0, alu_flag};
                            end
                        end
                    end
                    GRP_SKIP_NE_REG:
                    begin
                        if (vx_reg != vy_reg)
                        begin
                            pc_next = pc_skip;
                        end
                    end
                    GRP_SET_I:    i_next = {4'd0, fnnn};
                    GRP_JUMP_OFS: pc_next = fnnn + {4'd0, vy_reg};
                    GRP_RAND:     v_next[fx] = rnd_reg & fnn;
                    GRP_DRAW:
                    begin
                        if (fn == 4'd0)
                        begin
                            v_next[15] = 8'd0;
                        end
                    end
                    GRP_KEY:
                    begin
                        if (fnn == KEY_SKIP_DOWN)
                        begin
                            if (key_is_down)
                            begin
                                pc_next = pc_skip;
                            end
                        end
                        else if (fnn == KEY_SKIP_UP)
                        begin
                            if (!key_is_down)
                            begin
                                pc_next = pc_skip;
                            end
                        end
                        else
                        begin
                            status_next = STAT_BAD;
                        end
                    end
                    GRP_MISC:
                    begin
                        unique case (fnn)
                            MISC_DELAY_GET: v_next[fx] = delay_reg;
                            MISC_DELAY_SET: delay_next = vx_reg;
                            MISC_SOUND_SET: sound_next = vx_reg;
                            MISC_ADD_I:
                            begin
                                i_next     = add_i_sum[15:0];
                                v_next[15] = {7'd0, (add_i_sum > {5'd0, ADDR_MAX})};
                            end
                            MISC_WAIT_KEY:
                            begin
                                if (!krcv_reg)
                                begin
                                    pc_next     = pc_reg - 12'd2;
                                    status_next = STAT_WAIT;
                                end
                                else
                                begin
                                    v_next[fx] = {4'd0, lkey_reg};
                                    krcv_next  = 1'b0;
                                end
                            end
                            MISC_FONT:
                            begin
                                i_next = 16'(FONT_BASE) + 16'(vx_reg[3:0]) * 16'd5;
                            end
                            MISC_BCD, MISC_STORE, MISC_FILL: ;
                            default: status_next = STAT_BAD;
                        endcase
                    end
                    default: status_next = STAT_BAD;
                endcase
            end
            ST_CLEAR:
            begin
                if (fb_rd != 64'd0)
                begin
                    changed_next = 1'b1;
                end
                fb_next[cnt_reg] = 64'd0;
                cnt_next         = cnt_reg + 5'd1;
            end
            ST_RET:
            begin
                pc_next = stk_rdata;
            end
            ST_DRAW_RD:
            begin
                mem_raddr = i_cnt_addr;
            end
            ST_DRAW_WR:
            begin
                fb_next[draw_sum[4:0]] = fb_rd ^ sprite_bits;
                hit_next   = hit_reg || ((fb_rd & sprite_bits) != 64'd0);
                v_next[15] = {7'd0, hit_next};
                if (sprite_bits != 64'd0)
                begin
                    changed_next = 1'b1;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            ST_BCD:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_cnt_addr;
                mem_wdata = bcd_digit;
                cnt_next  = cnt_reg + 5'd1;
            end
            ST_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_cnt_addr;
                mem_wdata = v_reg[cnt_reg[3:0]];
                cnt_next  = cnt_reg + 5'd1;
            end
            ST_FILL_RD:
            begin
                mem_raddr = i_cnt_addr;
            end
            ST_FILL_WR:
            begin
                v_next[cnt_reg[3:0]] = mem_rdata;
                cnt_next             = cnt_reg + 5'd1;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                // idle and dispatch: start a fresh transaction on accept
                if (cmd.accept)
                begin
                    word_next    = 16'd0;
                    status_next  = STAT_OK;
                    changed_next = 1'b0;
                    row_next     = 64'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= START_PC;
            i_reg         <= 16'd0;
            sp_reg        <= '0;
            delay_reg     <= 8'd0;
            sound_reg     <= 8'd0;
            keys_reg      <= 16'd0;
            lkey_reg      <= 4'd0;
            krcv_reg      <= 1'b0;
            jump_vx_reg   <= 1'b1;
            init_cnt_reg  <= 12'd0;
            cnt_reg       <= 5'd0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= 8'd0;
            end
            for (int r = 0; r < SCREEN_HEIGHT; r++)
            begin
                fb_reg[r] <= 64'd0;
            end
        end
        else
        begin
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            delay_reg     <= delay_next;
            sound_reg     <= sound_next;
            keys_reg      <= keys_next;
            lkey_reg      <= lkey_next;
            krcv_reg      <= krcv_next;
            init_cnt_reg  <= init_cnt_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            v_reg         <= v_next;
            fb_reg        <= fb_next;
            if (cfg_valid)
            begin
                jump_vx_reg <= cfg_jump_uses_vx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= opcode;
            laddr_reg <= load_address;
            lbyte_reg <= load_byte;
            rnd_reg   <= random_byte;
            kidx_reg  <= key_index;
            kdown_reg <= key_down;
            rsel_reg  <= row_select;
        end
        word_reg    <= word_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        status_reg  <= status_next;
        changed_reg <= changed_next;
        row_reg     <= row_next;
        if (out_load)
        begin
            out_pc_reg      <= pc_reg;
            out_word_reg    <= word_reg;
            out_status_reg  <= status_reg;
            out_sound_reg   <= (sound_reg != 8'd0);
            out_changed_reg <= changed_reg;
            out_row_reg     <= row_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign program_counter = out_pc_reg;
    assign executed_word   = out_word_reg;
    assign status          = out_status_reg;
    assign sound_on        = out_sound_reg;
    assign screen_changed  = out_changed_reg;
    assign row_pixels      = out_row_reg;
endmodule

@@ src/chip8_instruction_execute_core.sv @@
// Top level of the CHIP-8 execute core: sequencer plus datapath.
//
// Channels: an input channel (in_valid/in_ready) carries one item per
// transaction: load byte, execute one instruction, timer tick, key event or
// framebuffer row read. The output channel (out_valid/out_ready) returns one
// result per item. A write channel (cfg_valid/cfg_ready) sets the Bnnn jump
// register source; it is always ready.
// Load, tick, key and row items pass dispatch and their own step before finish;
// an instruction is fetched, reads Vx and Vy and executes; 00EE adds a stack read.
// 00E0 clears one row a cycle, Dxyn reads and writes each drawn row, Fx33 writes
// three digits, Fx55 writes each register and Fx65 reads and writes each one.
// The single read port of main memory sets the sprite and Fx65 pace.
// One item is in flight at a time; the next one is taken in the cycle after the
// previous result is loaded into the output register, even while it waits there.
// Reset: a sweep writes zeros and the hex font into every address of main
// memory; in_ready stays low until it ends. Registers, timers, keys and the
// framebuffer clear at once; PC starts at 0x200.
// Stall: while out_ready is low the result holds and the core halts in its
// last step with the new result ready to load.
module chip8_instruction_execute_core #(
    parameter int STACK_DEPTH = 16,
    parameter int FONT_BASE   = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_jump_uses_vx,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [11:0] load_address,
    input  logic [7:0]  load_byte,
    input  logic [7:0]  random_byte,
    input  logic [3:0]  key_index,
    input  logic        key_down,
    input  logic [4:0]  row_select,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] program_counter,
    output logic [15:0] executed_word,
    output logic [2:0]  status,
    output logic        sound_on,
    output logic        screen_changed,
    output logic [63:0] row_pixels
);
    import c8x_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    c8x_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    c8x_dpath #(.STACK_DEPTH(STACK_DEPTH), .FONT_BASE(FONT_BASE)) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_valid        (cfg_valid),
        .cfg_jump_uses_vx (cfg_jump_uses_vx),
        .opcode           (opcode),
        .load_address     (load_address),
        .load_byte        (load_byte),
        .random_byte      (random_byte),
        .key_index        (key_index),
        .key_down         (key_down),
        .row_select       (row_select),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .program_counter  (program_counter),
        .executed_word    (executed_word),
        .status           (status),
        .sound_on         (sound_on),
        .screen_changed   (screen_changed),
        .row_pixels       (row_pixels)
    );
endmodule

@@ src/c8x_sva.sv @@
// Port-level checks of the CHIP-8 core and their binding.
module c8x_sva (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] executed_word
);
    import c8x_pkg::*;

    // one transaction at a time: ready drops after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(executed_word))
        else $error("stalled result changed");

    a_wait_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_WAIT |->
            executed_word[15:12] == 4'hF && executed_word[7:0] == MISC_WAIT_KEY)
        else $error("wait status from a word other than Fx0A");

    a_under_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_UNDER |-> executed_word == WORD_RET)
        else $error("underflow status from a word other than 00EE");
endmodule

bind chip8_instruction_execute_core c8x_sva u_sva (.*);

@@ test/chip8_exec_checker.sv @@
// Checker for the CHIP-8 execute core: predicts each result and compares it.
module chip8_exec_checker
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int FONT_BASE   = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_jump_uses_vx,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [11:0] load_address,
    input  logic [7:0]  load_byte,
    input  logic [7:0]  random_byte,
    input  logic [3:0]  key_index,
    input  logic        key_down,
    input  logic [4:0]  row_select,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [11:0] program_counter,
    input  logic [15:0] executed_word,
    input  logic [2:0]  status,
    input  logic        sound_on,
    input  logic        screen_changed,
    input  logic [63:0] row_pixels,
    output int          errors,
    output int          backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] word;
        logic [2:0]  st;
        logic        snd;
        logic        chg;
        logic [63:0] row;
    } core_result_t;

    core_result_t pending_results[$];

    logic [7:0]  mem [MEMORY_BYTES];
    logic [7:0]  v [16];
    logic [11:0] pc;
    logic [15:0] idx;
    logic [11:0] ret_stack [STACK_DEPTH];
    int          sp;
    logic [7:0]  delay_cnt;
    logic [7:0]  sound_cnt;
    logic [63:0] fb [SCREEN_HEIGHT];
    logic [15:0] keys;
    logic [3:0]  latched;
    logic        key_seen;
    logic        jump_vx;

    assign backlog = pending_results.size();

    task automatic reset_core();
        for (int i = 0; i < MEMORY_BYTES; i++)
        begin
            mem[i] = 8'h00;
        end
        for (int i = 0; i < FONT_BYTES; i++)
        begin
            mem[(FONT_BASE + i) % MEMORY_BYTES] = FONT_ROM[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            v[i] = 8'h00;
        end
        for (int i = 0; i < SCREEN_HEIGHT; i++)
        begin
            fb[i] = '0;
        end
        pc        = START_PC;
        idx       = '0;
        sp        = 0;
        delay_cnt = '0;
        sound_cnt = '0;
        keys      = '0;
        latched   = '0;
        key_seen  = 1'b0;
        jump_vx   = 1'b1;
    endtask

    // Execute one instruction word; returns the status code.
    function automatic logic [2:0] run_word(input logic [15:0] w, input logic [7:0] rnd,
                                           inout logic chg);
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [7:0]  res;
        logic        flag;
        logic [8:0]  sum9;
        logic [16:0] sum17;
        logic [5:0]  col;
        logic [4:0]  row0;
        logic [63:0] bits;
        logic        hit;
        logic        down;
        x   = w[11:8];
        y   = w[7:4];
        n   = w[3:0];
        nn  = w[7:0];
        nnn = w[11:0];
        vx  = v[x];
        vy  = v[y];
        case (w[15:12])
            GRP_SYS:
            begin
                if (w == WORD_CLS)
                begin
                    for (int i = 0; i < SCREEN_HEIGHT; i++)
                    begin
                        if (fb[i] != 0)
                        begin
                            chg = 1'b1;
                        end
                        fb[i] = '0;
                    end
                    return STAT_OK;
                end
                if (w == WORD_RET)
                begin
                    if (sp == 0)
                    begin
                        return STAT_UNDER;
                    end
                    sp--;
                    pc = ret_stack[sp];
                    return STAT_OK;
                end
                return STAT_BAD;
            end
            GRP_JUMP: pc = nnn;
            GRP_CALL:
            begin
                if (sp >= STACK_DEPTH)
                begin
                    return STAT_OVER;
                end
                ret_stack[sp] = pc;
                sp++;
                pc = nnn;
            end
            GRP_SKIP_EQ_IMM: if (vx == nn) pc = pc + 12'd2;
            GRP_SKIP_NE_IMM: if (vx != nn) pc = pc + 12'd2;
            GRP_SKIP_EQ_REG: if (vx == vy) pc = pc + 12'd2;
            GRP_SET_IMM:     v[x] = nn;
            GRP_ADD_IMM:     v[x] = vx + nn;
            GRP_ALU:
            begin
                case (n)
                    ALU_MOV: begin v[x] = vy; return STAT_OK; end
                    ALU_OR:  begin v[x] = vx | vy; return STAT_OK; end
                    ALU_AND: begin v[x] = vx & vy; return STAT_OK; end
                    ALU_XOR: begin v[x] = vx ^ vy; return STAT_OK; end
                    ALU_ADD:
                    begin
                        sum9 = {1'b0, vx} + {1'b0, vy};
                        res  = sum9[7:0];
                        flag = sum9[8];
                    end
                    ALU_SUB:  begin res = vx - vy; flag = (vx >= vy); end
                    ALU_SHR:  begin res = vy >> 1; flag = vy[0]; end
                    ALU_SUBN: begin res = vy - vx; flag = (vy >= vx); end
                    ALU_SHL:  begin res = vy << 1; flag = vy[7]; end
                    default: return STAT_BAD;
                endcase
                // flag goes in last, so it wins when x is VF
                v[x]  = res;
                v[15] = {7'd0, flag};
            end
            GRP_SKIP_NE_REG: if (vx != vy) pc = pc + 12'd2;
            GRP_SET_I:       idx = {4'h0, nnn};
            GRP_JUMP_OFS:    pc = nnn + {4'h0, (jump_vx ? vx : v[0])};
            GRP_RAND:        v[x] = rnd & nn;
            GRP_DRAW:
            begin
                col  = vx[5:0];
                row0 = vy[4:0];
                hit  = 1'b0;
                for (int i = 0; i < n && row0 + i < SCREEN_HEIGHT; i++)
                begin
                    bits = {mem[12'(idx + i)], 56'd0} >> col;
                    if ((fb[row0 + i] & bits) != 0)
                    begin
                        hit = 1'b1;
                    end
                    if (bits != 0)
                    begin
                        chg = 1'b1;
                    end
                    fb[row0 + i] ^= bits;
                end
                v[15] = {7'd0, hit};
            end
            GRP_KEY:
            begin
                down = keys[vx[3:0]];
                if (nn == KEY_SKIP_DOWN)
                begin
                    if (down) pc = pc + 12'd2;
                end
                else if (nn == KEY_SKIP_UP)
                begin
                    if (!down) pc = pc + 12'd2;
                end
                else
                begin
                    return STAT_BAD;
                end
            end
            default:
            begin
                case (nn)
                    MISC_DELAY_GET: v[x] = delay_cnt;
                    MISC_DELAY_SET: delay_cnt = vx;
                    MISC_SOUND_SET: sound_cnt = vx;
                    MISC_ADD_I:
                    begin
                        sum17 = {1'b0, idx} + {9'd0, vx};
                        idx   = sum17[15:0];
                        v[15] = {7'd0, (sum17 > 17'(ADDR_MAX))};
                    end
                    MISC_WAIT_KEY:
                    begin
                        if (!key_seen)
                        begin
                            pc = pc - 12'd2;
                            return STAT_WAIT;
                        end
                        v[x]     = {4'h0, latched};
                        key_seen = 1'b0;
                    end
                    MISC_FONT: idx = 16'(FONT_BASE + 5 * vx[3:0]);
                    MISC_BCD:
                    begin
                        mem[12'(idx)]      = vx / 100;
                        mem[12'(idx + 1)]  = (vx / 10) % 10;
                        mem[12'(idx + 2)]  = vx % 10;
                    end
                    MISC_STORE:
                    begin
                        for (int i = 0; i <= x; i++)
                        begin
                            mem[12'(idx + i)] = v[i];
                        end
                    end
                    MISC_FILL:
                    begin
                        for (int i = 0; i <= x; i++)
                        begin
                            v[i] = mem[12'(idx + i)];
                        end
                    end
                    default: return STAT_BAD;
                endcase
            end
        endcase
        return STAT_OK;
    endfunction

    function automatic core_result_t emulate_item(input logic [2:0] kind);
        core_result_t r;
        r = '0;
        case (kind)
            KIND_LOAD: mem[load_address] = load_byte;
            KIND_EXEC:
            begin
                r.word = {mem[pc], mem[pc + 12'd1]};
                pc     = pc + 12'd2;
                r.st   = run_word(r.word, random_byte, r.chg);
            end
            KIND_TICK:
            begin
                if (delay_cnt != 0) delay_cnt--;
                if (sound_cnt != 0) sound_cnt--;
            end
            KIND_KEY:
            begin
                if (key_down)
                begin
                    keys[key_index] = 1'b1;
                    latched         = key_index;
                    key_seen        = 1'b1;
                end
                else
                begin
                    keys[key_index] = 1'b0;
                end
            end
            KIND_ROW: r.row = fb[row_select];
            default:  r.st = STAT_BAD;
        endcase
        r.pc  = pc;
        r.snd = (sound_cnt != 0);
        return r;
    endfunction

    initial
    begin
        errors = 0;
        reset_core();
    end

    always @(posedge clk or negedge rst_n)
    begin
        core_result_t want;
        if (!rst_n)
        begin
            reset_core();
            pending_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                jump_vx = cfg_jump_uses_vx;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (program_counter !== want.pc)
                    begin
                        $error("program_counter expected %h actual %h", want.pc, program_counter);
                        errors++;
                    end
                    if (executed_word !== want.word)
                    begin
                        $error("executed_word expected %h actual %h", want.word, executed_word);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status expected %0d actual %0d", want.st, status);
                        errors++;
                    end
                    if (sound_on !== want.snd)
                    begin
                        $error("sound_on expected %b actual %b", want.snd, sound_on);
                        errors++;
                    end
                    if (screen_changed !== want.chg)
                    begin
                        $error("screen_changed expected %b actual %b", want.chg, screen_changed);
                        errors++;
                    end
                    if (row_pixels !== want.row)
                    begin
                        $error("row_pixels expected %h actual %h", want.row, row_pixels);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_results.push_back(emulate_item(opcode));
            end
        end
    end

endmodule

@@ test/tb_chip8_instruction_execute_core.sv @@
// Testbench top for the CHIP-8 execute core: clock, reset, stimulus and verdict.
module tb_chip8_instruction_execute_core;
    import c8x_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_jump_uses_vx;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  random_byte;
    logic [3:0]  key_index;
    logic        key_down;
    logic [4:0]  row_select;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] program_counter;
    logic [15:0] executed_word;
    logic [2:0]  status;
    logic        sound_on;
    logic        screen_changed;
    logic [63:0] row_pixels;

    int          errors;
    int          backlog;
    int          sent_count;
    int          done_count;
    int          item_count;
    int          tx_idle;
    int          rx_idle;
    int          cycles;
    logic [11:0] last_pc;
    bit          hold_start;

    chip8_instruction_execute_core DUT (.*);

    chip8_exec_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_count <= 0;
            done_count <= 0;
            last_pc    <= START_PC;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                sent_count <= sent_count + 1;
            end
            if (out_valid && out_ready)
            begin
                done_count <= done_count + 1;
                last_pc    <= program_counter;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("chip8_instruction_execute_core: mismatch");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [11:0] addr,
                             input logic [7:0] data);
        if ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= kind;
        load_address <= addr;
        load_byte    <= data;
        random_byte  <= 8'($urandom);
        key_index    <= 4'($urandom);
        key_down     <= 1'($urandom);
        row_select   <= 5'($urandom);
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        item_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sent_count != done_count)
        begin
            @(posedge clk);
        end
    endtask

    // Place a word at the current PC, then execute it.
    task automatic run_word(input logic [15:0] w);
        logic [11:0] at;
        drain();
        at = last_pc;
        send_item(KIND_LOAD, at, w[15:8]);
        send_item(KIND_LOAD, at + 12'd1, w[7:0]);
        send_item(KIND_EXEC, 12'($urandom), 8'($urandom));
    endtask

    task automatic write_jump_mode(input logic mode);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_valid        <= 1'b1;
        cfg_jump_uses_vx <= mode;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        int          r;
        logic [7:0]  misc_codes [9];
        misc_codes = '{MISC_DELAY_GET, MISC_WAIT_KEY, MISC_DELAY_SET, MISC_SOUND_SET,
                       MISC_ADD_I, MISC_FONT, MISC_BCD, MISC_STORE, MISC_FILL};
        w = 16'($urandom);
        r = $urandom_range(0, 99);
        // lean on calls so the stack fills up and overflows now and then
        if (r < 12)
        begin
            w[15:12] = GRP_CALL;
            return w;
        end
        if (r < 18)
        begin
            return WORD_RET;
        end
        case (w[15:12])
            GRP_SYS:
            begin
                r = $urandom_range(0, 9);
                if (r < 4) w = WORD_CLS;
                else if (r < 7) w = WORD_RET;
            end
            GRP_KEY:
            begin
                r = $urandom_range(0, 9);
                if (r < 4) w[7:0] = KEY_SKIP_DOWN;
                else if (r < 8) w[7:0] = KEY_SKIP_UP;
            end
            GRP_MISC:
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    w[7:0] = misc_codes[$urandom_range(0, 8)];
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic random_phase(input int quota, input bit squeeze);
        int r;
        int stop_at;
        stop_at = item_count + quota;
        while (item_count < stop_at)
        begin
            if (squeeze && item_count > stop_at - quota / 2)
            begin
                // hold the output off while status items keep coming
                squeeze    = 1'b0;
                hold_start = 1'b1;
                repeat (20) send_item(KIND_TICK + 3'($urandom_range(0, 2)), 12'($urandom),
                                      8'($urandom));
            end
            r = $urandom_range(0, 99);
            if (r < 55) run_word(pick_word());
            else if (r < 58) send_item(KIND_EXEC, 12'($urandom), 8'($urandom));
            else if (r < 66) send_item(KIND_LOAD, 12'($urandom), 8'($urandom));
            else if (r < 75) send_item(KIND_TICK, 12'($urandom), 8'($urandom));
            else if (r < 85) send_item(KIND_KEY, 12'($urandom), 8'($urandom));
            else if (r < 96) send_item(KIND_ROW, 12'($urandom), 8'($urandom));
            else send_item(3'($urandom_range(5, 7)), 12'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        cycles           = 0;
        item_count       = 0;
        hold_start       = 1'b0;
        tx_idle          = 0;
        rx_idle          = 0;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_jump_uses_vx = 1'b0;
        in_valid         = 1'b0;
        opcode           = KIND_LOAD;
        load_address     = '0;
        load_byte        = '0;
        random_byte      = '0;
        key_index        = '0;
        key_down         = 1'b0;
        row_select       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_jump_mode(1'b1);
        // directed: empty-stack return, row reads, unknown kinds, keys, wait, draw, clear
        run_word(WORD_RET);
        send_item(KIND_ROW, 12'h000, 8'h00);
        send_item(KIND_LOAD, 12'hFFF, 8'hFF);
        send_item(3'd5, 12'hFFF, 8'h00);
        send_item(3'd7, 12'h000, 8'hFF);
        send_item(KIND_KEY, 12'h000, 8'h00);
        send_item(KIND_TICK, 12'h000, 8'h00);
        run_word(16'hF50A);
        run_word(16'hF00A);
        run_word(16'hF529);
        run_word(16'hD55F);
        send_item(KIND_ROW, 12'h000, 8'h00);
        run_word(WORD_CLS);

        write_jump_mode(1'b0);
        tx_idle = 9;
        rx_idle = 80;
        random_phase(310, 1'b0);

        write_jump_mode(1'b1);
        tx_idle = 80;
        rx_idle = 9;
        random_phase(310, 1'b1);

        write_jump_mode(1'b0);
        tx_idle = 0;
        rx_idle = 0;
        random_phase(310, 1'b0);

        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && backlog == 0)
        begin
            $display("chip8_instruction_execute_core: match");
        end
        else
        begin
            $display("chip8_instruction_execute_core: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/c8x_pkg.sv
src/c8x_ram.sv
src/c8x_ctrl.sv
src/c8x_dpath.sv
src/chip8_instruction_execute_core.sv
src/c8x_sva.sv
test/chip8_exec_checker.sv
test/tb_chip8_instruction_execute_core.sv
